@@ hdl/pda_pkg.sv @@
// Package for the PID controller with dead zone and integral clamp.
// Holds the sequencer states, register indexes and fixed datapath widths.
// No dependencies.
package pda_pkg;

   localparam int DATA_W     = 32;
   localparam int CH_W       = 3;
   localparam int ADDR_W     = 5;
   localparam int DECAY_BITS = 16;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUM_W      = PROD_W + 2;

   localparam logic [2:0] REG_KP    = 3'd0;
   localparam logic [2:0] REG_KI    = 3'd1;
   localparam logic [2:0] REG_KD    = 3'd2;
   localparam logic [2:0] REG_DT    = 3'd3;
   localparam logic [2:0] REG_LIMIT = 3'd4;
   localparam logic [2:0] REG_DECAY = 3'd5;
   localparam logic [2:0] REG_DZONE = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MUL_INT,
      S_INTEG,
      S_MUL_I,
      S_MUL_D,
      S_SUM,
      S_DONE
   } state_type;

endpackage

@@ hdl/pid_deadzone_antiwindup.sv @@
// Top level of the multi-channel PID controller with dead zone and integral clamp.
// Contains the register file, the per-channel state and the shared multiplier sequencer.
// Depends on pda_pkg.
//
// Usage: the input channel (req_) takes one word holding a channel number and a signed
// error. The result channel (rsp_) returns one word per input with the channel echoed
// and the saturated drive value. Registers are written through the APB-style port and
// should only be changed while no word is in flight.
// Each word runs these steps from acceptance to the result register: one load step, one
// 33x33 signed multiplier used four times in sequence (integral term, then the P, I and
// D products), and the final sum and saturation each take one more step. req_ready is
// high only while the sequencer is idle, so no word is accepted while another is in flight.
// A word for a channel at or beyond CHANNELS skips the multiplier and goes from the load
// step straight to the result step.
// A finished result waits in the output register while the next word is accepted;
// if the receiver still stalls when the next result is ready, the sequencer holds in
// its last step until the output register is free.
// Reset clears the registers to their defaults and the integral and previous error of
// every channel to zero. Channel numbers at or beyond CHANNELS return a drive of zero
// and leave all state untouched.
module pid_deadzone_antiwindup
   import pda_pkg::*;
#(
   parameter int CHANNELS  = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CH_W-1:0]          req_channel,
   input  logic signed [DATA_W-1:0] req_error_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CH_W-1:0]          rsp_result_channel,
   output logic signed [DATA_W-1:0] rsp_drive,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   localparam int STATE_DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
   localparam int IDX_W       = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [30:0]              dt_ff, limit_ff, dzone_ff;
   logic [16:0]              decay_ff;

   logic signed [DATA_W-1:0] acc_mem [STATE_DEPTH];
   logic signed [DATA_W-1:0] prev_mem [STATE_DEPTH];

   logic [CH_W-1:0]          ch_ff;
   logic signed [DATA_W-1:0] e_ff, acc_ff, prev_ff, s_ff;
   logic                     zero_ff, in_range_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     rsp_valid_ff;
   logic [CH_W-1:0]          rsp_ch_ff;
   logic signed [DATA_W-1:0] rsp_drive_ff;

   logic                     accept, out_free, out_load, cfg_wr;
   logic [2:0]               reg_idx;
   logic [IDX_W-1:0]         idx;
   logic signed [MUL_W-1:0]  mul_a, mul_b, e_mag, diff;
   logic signed [PROD_W-1:0] mul_p, integ_sum, dec_sh, lim_w;
   logic signed [SUM_W-1:0]  sum_sh;
   logic signed [DATA_W-1:0] s_next, drive_sat;
   logic                     dead, in_range;

   assign pready    = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == S_DONE) && out_free;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[4:2];
   assign idx       = ch_ff[IDX_W-1:0];

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_channel = rsp_ch_ff;
   assign rsp_drive          = rsp_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
         dt_ff    <= 31'd65536;
         limit_ff <= 31'h7FFF_FFFF;
         decay_ff <= 17'd65536;
         dzone_ff <= '0;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_KP:    kp_ff    <= pwdata;
            REG_KI:    ki_ff    <= pwdata;
            REG_KD:    kd_ff    <= pwdata;
            REG_DT:    dt_ff    <= pwdata[30:0];
            REG_LIMIT: limit_ff <= pwdata[30:0];
            REG_DECAY: decay_ff <= pwdata[16:0];
            REG_DZONE: dzone_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KP:    prdata = kp_ff;
         REG_KI:    prdata = ki_ff;
         REG_KD:    prdata = kd_ff;
         REG_DT:    prdata = {1'b0, dt_ff};
         REG_LIMIT: prdata = {1'b0, limit_ff};
         REG_DECAY: prdata = {15'd0, decay_ff};
         REG_DZONE: prdata = {1'b0, dzone_ff};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = in_range ? S_MUL_INT : S_DONE;
         end
         S_MUL_INT: begin
            if (zero_ff) begin
               mul_a = MUL_W'(acc_ff);
               mul_b = $signed({16'd0, decay_ff});
            end else begin
               mul_a = MUL_W'(e_ff);
               mul_b = $signed({2'b0, dt_ff});
            end
            state_in = S_INTEG;
         end
         S_INTEG: begin
            mul_a    = MUL_W'(e_ff);
            mul_b    = MUL_W'(kp_ff);
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            mul_a    = MUL_W'(s_ff);
            mul_b    = MUL_W'(ki_ff);
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            mul_a    = diff;
            mul_b    = MUL_W'(kd_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign e_mag    = e_ff[DATA_W-1] ? -MUL_W'(e_ff) : MUL_W'(e_ff);
   assign dead     = e_mag < $signed({2'b0, dzone_ff});
   assign in_range = {29'd0, ch_ff} < 32'(CHANNELS);
   assign diff     = MUL_W'(e_ff) - MUL_W'(prev_ff);

   assign lim_w     = $signed({35'd0, limit_ff});
   assign integ_sum = PROD_W'(acc_ff) + (prod_ff >>> FRAC_BITS);
   assign dec_sh    = prod_ff >>> DECAY_BITS;

   always_comb begin
      if (zero_ff) begin
         if (dec_sh[PROD_W-1:DATA_W-1] == '0 || dec_sh[PROD_W-1:DATA_W-1] == '1) begin
            s_next = dec_sh[DATA_W-1:0];
         end else begin
            s_next = dec_sh[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end
      end else if (integ_sum > lim_w) begin
         s_next = lim_w[DATA_W-1:0];
      end else if (integ_sum < -lim_w) begin
         s_next = DATA_W'(-lim_w);
      end else begin
         s_next = integ_sum[DATA_W-1:0];
      end
   end

   assign sum_sh = sum_ff >>> FRAC_BITS;

   always_comb begin
      if (sum_sh[SUM_W-1:DATA_W-1] == '0 || sum_sh[SUM_W-1:DATA_W-1] == '1) begin
         drive_sat = sum_sh[DATA_W-1:0];
      end else begin
         drive_sat = sum_sh[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ch_ff <= req_channel;
               e_ff  <= req_error_sample;
            end
         end
         S_LOAD: begin
            if (dead) begin
               e_ff <= '0;
            end
            zero_ff     <= dead || (e_ff == '0);
            in_range_ff <= in_range;
            acc_ff      <= acc_mem[idx];
            prev_ff     <= prev_mem[idx];
            sum_ff      <= '0;
         end
         S_INTEG: begin
            s_ff <= s_next;
         end
         S_MUL_I, S_MUL_D, S_SUM: begin
            sum_ff <= sum_ff + SUM_W'(prod_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATE_DEPTH; i++) begin
            acc_mem[i]  <= '0;
            prev_mem[i] <= '0;
         end
      end else if (out_load && in_range_ff) begin
         acc_mem[idx]  <= s_ff;
         prev_mem[idx] <= e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ch_ff    <= ch_ff;
         rsp_drive_ff <= drive_sat;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOAD))
      else $error("accepted word did not start the sequencer");

   a_sum_then_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> (state_ff == S_DONE))
      else $error("sequencer skipped the result step");

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result appeared without a finished word");

   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("finished word was not handed to the output register");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the multi-channel PID controller with dead zone and clamp.
// Runs a directed stimulus plan, then random words under many register settings.
// Depends on pda_pkg and pid_deadzone_antiwindup.
module tb_top
   import pda_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS     = 16;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 128;
   localparam int BURST_WORDS   = 24;
   localparam int LONG_HOLD     = 300;
   localparam int TIMEOUT_NS    = 5_000_000;

   localparam logic [2:0] REG_NONE = 3'd7;

   typedef enum logic { ROW_WORD, ROW_WRITE } row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [2:0]              reg_idx;
      logic [DATA_W-1:0]       value;
      logic [CH_W-1:0]         ch;
      logic signed [DATA_W-1:0] err;
      bit                      typed;
      logic signed [DATA_W-1:0] drive;
   } plan_row_type;

   typedef struct packed {
      logic [CH_W-1:0]          ch;
      logic signed [DATA_W-1:0] drive;
   } drive_word_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CH_W-1:0]          req_channel = '0;
   logic signed [DATA_W-1:0] req_error_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CH_W-1:0]          rsp_result_channel;
   logic signed [DATA_W-1:0] rsp_drive;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // Predictor copy of the registers and of the per-channel state.
   logic signed [31:0] kp_cfg, ki_cfg, kd_cfg;
   logic [30:0]        dt_cfg, lim_cfg, dz_cfg;
   logic [16:0]        decay_cfg;
   logic signed [31:0] integ_state [8];
   logic signed [31:0] last_err [8];

   drive_word_type pending_drives [$];
   plan_row_type   directed_plan [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int words_sent = 0;
   int drives_checked = 0;
   int mismatches = 0;
   int settings_used = 0;

   pid_deadzone_antiwindup u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel        (req_channel),
      .req_error_sample   (req_error_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_channel (rsp_result_channel),
      .rsp_drive          (rsp_drive),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] saturate32(input logic signed [69:0] v);
      if (v > 70'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -70'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Computes the drive for one word and advances the channel's integral and last error.
   function automatic logic signed [31:0] predict_drive(input logic [2:0] ch,
                                                        input logic signed [31:0] err);
      longint             e_in, mag, integ;
      logic signed [69:0] p_term, i_term, d_term, total;
      e_in = err;
      mag = (e_in < 0) ? -e_in : e_in;
      if (mag < longint'(dz_cfg)) e_in = 0;
      if (e_in != 0) begin
         integ = longint'(integ_state[ch]) + ((e_in * longint'(dt_cfg)) >>> FRAC_BITS);
         if (integ > longint'(lim_cfg)) integ = longint'(lim_cfg);
         else if (integ < -longint'(lim_cfg)) integ = -longint'(lim_cfg);
      end else begin
         integ = (longint'(integ_state[ch]) * longint'(decay_cfg)) >>> DECAY_BITS;
         integ = longint'(saturate32(integ));
      end
      p_term = e_in * kp_cfg;
      i_term = integ * ki_cfg;
      d_term = (e_in - longint'(last_err[ch])) * kd_cfg;
      total = (p_term + i_term + d_term) >>> FRAC_BITS;
      integ_state[ch] = integ[31:0];
      last_err[ch] = e_in[31:0];
      return saturate32(total);
   endfunction

   function automatic void plan_word(input logic [2:0] ch, input logic [31:0] err,
                                     input bit typed, input logic [31:0] drive);
      plan_row_type row;
      row = '{ROW_WORD, REG_NONE, '0, ch, err, typed, drive};
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_write(input logic [2:0] reg_idx, input logic [31:0] value);
      plan_row_type row;
      row = '{ROW_WRITE, reg_idx, value, '0, '0, 1'b0, '0};
      directed_plan.push_back(row);
   endfunction

   function automatic logic [31:0] random_gain();
      if ($urandom_range(1) == 1) return $urandom;
      return $urandom_range(0, 1 << 19) - (1 << 18);
   endfunction

   function automatic logic [31:0] random_error();
      logic [31:0] near;
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(0, 1 << 18) - (1 << 17);
         4, 5: return $urandom;
         6: return '0;
         7, 8: begin
            near = {1'b0, dz_cfg} + $urandom_range(0, 2) - 1;
            return ($urandom_range(1) == 1) ? near : -near;
         end
         default: begin
            case ($urandom_range(3))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'h00000001;
               default: return 32'hFFFFFFFF;
            endcase
         end
      endcase
   endfunction

   task automatic csr_write(input logic [2:0] reg_idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_idx)
         REG_KP:    kp_cfg = value;
         REG_KI:    ki_cfg = value;
         REG_KD:    kd_cfg = value;
         REG_DT:    dt_cfg = value[30:0];
         REG_LIMIT: lim_cfg = value[30:0];
         REG_DECAY: decay_cfg = value[16:0];
         REG_DZONE: dz_cfg = value[30:0];
         default: ;
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(input logic [2:0] ch, input logic [31:0] err,
                            input bit typed, input logic [31:0] typed_drive);
      drive_word_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_error_sample <= err;
      do @(posedge clock); while (!req_ready);
      want.ch = ch;
      want.drive = predict_drive(ch, err);
      if (typed) want.drive = typed_drive;
      pending_drives.push_back(want);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_drives.size() != 0);
   endtask

   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            $display("%0t: unexpected word, channel %0d drive %0d", $time,
                     rsp_result_channel, rsp_drive);
            mismatches++;
         end else begin
            want = pending_drives.pop_front();
            drives_checked++;
            if (rsp_result_channel !== want.ch) begin
               $display("%0t: channel mismatch, expected %0d, actual %0d", $time,
                        want.ch, rsp_result_channel);
               mismatches++;
            end
            if (rsp_drive !== want.drive) begin
               $display("%0t: drive mismatch on channel %0d, expected %0d, actual %0d",
                        $time, want.ch, want.drive, rsp_drive);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [31:0] setting [7];
      kp_cfg = '0;
      ki_cfg = '0;
      kd_cfg = '0;
      dt_cfg = 31'd65536;
      lim_cfg = 31'h7FFFFFFF;
      decay_cfg = 17'd65536;
      dz_cfg = '0;
      for (int c = 0; c < 8; c++) begin
         integ_state[c] = '0;
         last_err[c] = '0;
      end

      // With all gains at zero after reset, every drive is zero.
      plan_word(3'd0, 32'h7FFFFFFF, 1'b1, 32'h0);
      plan_word(3'd7, 32'h80000000, 1'b1, 32'h0);
      plan_write(REG_KP, 32'h7FFFFFFF);
      plan_word(3'd1, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF);
      plan_word(3'd2, 32'h80000000, 1'b1, 32'h80000000);
      plan_write(REG_KP, 32'h80000000);
      plan_word(3'd3, 32'h80000000, 1'b1, 32'h7FFFFFFF);
      plan_write(REG_KP, 32'h00010000);
      plan_word(3'd4, 32'd12345, 1'b1, 32'd12345);
      plan_word(3'd4, 32'h0, 1'b1, 32'h0);
      plan_write(REG_DZONE, 32'd1000);
      plan_word(3'd5, 32'd999, 1'b1, 32'h0);
      plan_word(3'd5, -32'sd999, 1'b1, 32'h0);
      plan_word(3'd5, -32'sd1000, 1'b1, -32'sd1000);
      plan_write(REG_DZONE, 32'h0);
      plan_write(REG_KI, 32'h00010000);
      // A zero time step leaves the integral where it was.
      plan_write(REG_DT, 32'h0);
      plan_word(3'd6, 32'd5000, 1'b0, 32'h0);
      plan_write(REG_DT, 32'h7FFFFFFF);
      plan_write(REG_LIMIT, 32'd100);
      plan_word(3'd0, 32'h7FFFFFFF, 1'b0, 32'h0);
      plan_write(REG_KD, 32'h7FFFFFFF);
      plan_word(3'd1, 32'h80000000, 1'b0, 32'h0);
      // Decay above one makes the integral grow until it saturates.
      plan_write(REG_DECAY, 32'h0001FFFF);
      plan_word(3'd3, 32'h0, 1'b0, 32'h0);
      plan_word(3'd3, 32'h0, 1'b0, 32'h0);
      // A negative integral halving toward zero settles at minus one.
      plan_write(REG_DT, 32'h00010000);
      plan_write(REG_LIMIT, 32'd5);
      plan_write(REG_DECAY, 32'd32768);
      plan_word(3'd2, -32'sd3, 1'b0, 32'h0);
      for (int k = 0; k < 5; k++) plan_word(3'd2, 32'h0, 1'b0, 32'h0);
      // The unused register address must be ignored.
      plan_write(REG_NONE, 32'hFFFFFFFF);
      plan_word(3'd7, 32'h00010000, 1'b0, 32'h0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[k]) begin
         if (directed_plan[k].kind == ROW_WRITE) begin
            wait_drained();
            csr_write(directed_plan[k].reg_idx, directed_plan[k].value);
         end else begin
            send_word(directed_plan[k].ch, directed_plan[k].err, directed_plan[k].typed,
                      directed_plan[k].drive);
         end
      end
      settings_used = 1;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         case (ph)
            0: begin
               setting[REG_KP] = 32'h7FFFFFFF;
               setting[REG_KI] = 32'h7FFFFFFF;
               setting[REG_KD] = 32'h7FFFFFFF;
               setting[REG_DT] = 32'h7FFFFFFF;
               setting[REG_LIMIT] = 32'h7FFFFFFF;
               setting[REG_DECAY] = 32'h0001FFFF;
               setting[REG_DZONE] = 32'h7FFFFFFF;
            end
            1: begin
               setting[REG_KP] = 32'h80000000;
               setting[REG_KI] = 32'h80000000;
               setting[REG_KD] = 32'h80000000;
               setting[REG_DT] = 32'h1;
               setting[REG_LIMIT] = 32'h0;
               setting[REG_DECAY] = 32'h0;
               setting[REG_DZONE] = 32'h0;
            end
            default: begin
               setting[REG_KP] = random_gain();
               setting[REG_KI] = random_gain();
               setting[REG_KD] = random_gain();
               setting[REG_DT] = ($urandom_range(2) == 0) ? $urandom
                                                          : $urandom_range(1 << 12, 1 << 17);
               setting[REG_LIMIT] = ($urandom_range(1) == 1) ? $urandom
                                                             : $urandom_range(0, 1 << 22);
               setting[REG_DECAY] = ($urandom_range(4) == 0) ? $urandom_range(65537, 131071)
                                                             : $urandom_range(0, 65536);
               case ($urandom_range(9))
                  0, 1, 2, 3, 4: setting[REG_DZONE] = 32'h0;
                  9: setting[REG_DZONE] = $urandom;
                  default: setting[REG_DZONE] = $urandom_range(0, 1 << 16);
               endcase
               // Decay of one and no dead zone give the plain controller.
               if (ph == 2) begin
                  setting[REG_DECAY] = 32'd65536;
                  setting[REG_DZONE] = 32'h0;
               end
            end
         endcase
         for (int r = REG_KP; r <= REG_DZONE; r++) csr_write(3'(r), setting[r]);
         settings_used++;
         for (int n = 0; n < PHASE_WORDS; n++)
            send_word(3'($urandom_range(7)), random_error(), 1'b0, 32'h0);

         // The receiver holds off while words keep coming, so the block backs up.
         if (ph == 3) begin
            wait_drained();
            send_idle_pct = 0;
            hold_requests++;
            for (int n = 0; n < BURST_WORDS; n++)
               send_word(3'($urandom_range(7)), random_error(), 1'b0, 32'h0);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d words under %0d register settings; %0d drive words checked.",
               words_sent, settings_used, drives_checked);
      $display("Idle and stall mixes, a long receiver hold-off and %0d mismatches seen.",
               mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/pda_pkg.sv
hdl/pid_deadzone_antiwindup.sv
tb/sv/tb_top.sv
